// File: rtl/rcrm_pkg.sv
package rcrm_pkg;

  localparam int DEF_WORKER_SLOTS   = 32;
  localparam int DEF_RESOURCE_KINDS = 16;
  localparam int DEF_INSTANCES      = 20;

  localparam int ACTION_W    = 2;
  localparam int WORKER_W    = 5;
  localparam int RESOURCE_W  = 4;
  localparam int KIND_W      = 3;
  localparam int REMAINING_W = 5;

  typedef logic [WORKER_W-1:0]    worker_t;
  typedef logic [RESOURCE_W-1:0]  resource_t;
  typedef logic [REMAINING_W-1:0] remaining_t;

  typedef enum logic [ACTION_W-1:0] {
    ACT_CLAIM     = 2'd0,
    ACT_RELEASE   = 2'd1,
    ACT_TERMINATE = 2'd2,
    ACT_ACTIVATE  = 2'd3
  } act_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_GRANTED  = 3'd0,
    KIND_RELEASED = 3'd1,
    KIND_BLOCKED  = 3'd2,
    KIND_WOKEN    = 3'd3,
    KIND_DONE     = 3'd4,
    KIND_ERROR    = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    SLOT_FREE    = 2'd0,
    SLOT_RUNNING = 2'd1,
    SLOT_BLOCKED = 2'd2
  } slot_t;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_ACCEPT,
    OP_LOOK,
    OP_DECIDE,
    OP_TRD,
    OP_TWR,
    OP_TDONE,
    OP_SCAN,
    OP_WWR,
    OP_FLUSH
  } op_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_DECIDE,
    ST_TRD,
    ST_TWR,
    ST_TDONE,
    ST_SCAN,
    ST_WAKE,
    ST_FLUSH
  } ctrl_state_t;

  typedef struct packed {
    op_t  op;
    logic cnt_clr;
    logic cnt_inc;
  } cmd_t;

  typedef struct packed {
    logic term_go;
    logic wakeable;
    logic out_free;
    logic cnt_last_addr;
    logic cnt_last_slot;
    logic cnt_last_kind;
  } stat_t;

endpackage

// File: rtl/rcrm_ram.sv
module rcrm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: rtl/rcrm_ctrl.sv
module rcrm_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  rcrm_pkg::stat_t stat,
  output rcrm_pkg::cmd_t  cmd
);

  rcrm_pkg::ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rcrm_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      rcrm_pkg::ST_CLEAR:  if (stat.cnt_last_addr) state_next = rcrm_pkg::ST_IDLE;
      rcrm_pkg::ST_IDLE:   if (in_valid) state_next = rcrm_pkg::ST_LOOK;
      rcrm_pkg::ST_LOOK:   state_next = rcrm_pkg::ST_DECIDE;
      rcrm_pkg::ST_DECIDE: begin
        state_next = stat.term_go ? rcrm_pkg::ST_TRD : rcrm_pkg::ST_SCAN;
      end
      rcrm_pkg::ST_TRD:    state_next = rcrm_pkg::ST_TWR;
      rcrm_pkg::ST_TWR: begin
        state_next = stat.cnt_last_kind ? rcrm_pkg::ST_TDONE : rcrm_pkg::ST_TRD;
      end
      rcrm_pkg::ST_TDONE:  state_next = rcrm_pkg::ST_SCAN;
      rcrm_pkg::ST_SCAN: begin
        if (stat.wakeable) begin
          state_next = rcrm_pkg::ST_WAKE;
        end else if (stat.cnt_last_slot) begin
          state_next = rcrm_pkg::ST_FLUSH;
        end
      end
      rcrm_pkg::ST_WAKE: begin
        if (stat.out_free) begin
          state_next = stat.cnt_last_slot ? rcrm_pkg::ST_FLUSH : rcrm_pkg::ST_SCAN;
        end
      end
      rcrm_pkg::ST_FLUSH:  if (stat.out_free) state_next = rcrm_pkg::ST_IDLE;
      default:             state_next = rcrm_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd.op      = rcrm_pkg::OP_NONE;
    cmd.cnt_clr = 1'b0;
    cmd.cnt_inc = 1'b0;
    unique case (state)
      rcrm_pkg::ST_CLEAR: begin
        cmd.op      = rcrm_pkg::OP_CLEAR;
        cmd.cnt_clr = stat.cnt_last_addr;
        cmd.cnt_inc = !stat.cnt_last_addr;
      end
      rcrm_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = rcrm_pkg::OP_ACCEPT;
      end
      rcrm_pkg::ST_LOOK:   cmd.op = rcrm_pkg::OP_LOOK;
      rcrm_pkg::ST_DECIDE: begin
        // a valid terminate posts its result after the row sweep
        if (!stat.term_go) cmd.op = rcrm_pkg::OP_DECIDE;
        cmd.cnt_clr = 1'b1;
      end
      rcrm_pkg::ST_TRD:    cmd.op = rcrm_pkg::OP_TRD;
      rcrm_pkg::ST_TWR: begin
        cmd.op      = rcrm_pkg::OP_TWR;
        cmd.cnt_clr = stat.cnt_last_kind;
        cmd.cnt_inc = !stat.cnt_last_kind;
      end
      rcrm_pkg::ST_TDONE:  cmd.op = rcrm_pkg::OP_TDONE;
      rcrm_pkg::ST_SCAN: begin
        cmd.op      = rcrm_pkg::OP_SCAN;
        cmd.cnt_inc = !stat.wakeable && !stat.cnt_last_slot;
      end
      rcrm_pkg::ST_WAKE: begin
        if (stat.out_free) begin
          cmd.op      = rcrm_pkg::OP_WWR;
          cmd.cnt_inc = !stat.cnt_last_slot;
        end else begin
          // keep the held-count read on the woken slot while the output is busy
          cmd.op = rcrm_pkg::OP_SCAN;
        end
      end
      rcrm_pkg::ST_FLUSH: begin
        if (stat.out_free) cmd.op = rcrm_pkg::OP_FLUSH;
      end
      default: cmd.op = rcrm_pkg::OP_NONE;
    endcase
  end

endmodule

// File: rtl/rcrm_dp.sv
module rcrm_dp #(
  parameter int WORKER_SLOTS   = rcrm_pkg::DEF_WORKER_SLOTS,
  parameter int RESOURCE_KINDS = rcrm_pkg::DEF_RESOURCE_KINDS,
  parameter int INSTANCES      = rcrm_pkg::DEF_INSTANCES
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [rcrm_pkg::ACTION_W-1:0] action,
  input  rcrm_pkg::worker_t           worker,
  input  rcrm_pkg::resource_t         resource,
  input  rcrm_pkg::cmd_t              cmd,
  output rcrm_pkg::stat_t             stat,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [rcrm_pkg::KIND_W-1:0] kind,
  output rcrm_pkg::worker_t           worker_out,
  output rcrm_pkg::resource_t         resource_out,
  output rcrm_pkg::remaining_t        remaining,
  output logic                        last
);

  localparam int SW    = $clog2(WORKER_SLOTS);
  localparam int RW    = (RESOURCE_KINDS > 1) ? $clog2(RESOURCE_KINDS) : 1;
  localparam int AW    = SW + RW;
  localparam int DEPTH = 1 << AW;
  localparam int CW    = $clog2(INSTANCES + 1);

  // latched item
  rcrm_pkg::act_t      req_action;
  rcrm_pkg::worker_t   req_worker;
  rcrm_pkg::resource_t req_resource;

  rcrm_pkg::slot_t slot_state [WORKER_SLOTS];
  logic [RW-1:0]   wanted     [WORKER_SLOTS];
  logic [CW-1:0]   available  [RESOURCE_KINDS];
  logic [AW-1:0]   cnt;

  // staged result, waits until its last flag is known
  rcrm_pkg::kind_t      pend_kind;
  rcrm_pkg::worker_t    pend_worker;
  rcrm_pkg::resource_t  pend_resource;
  rcrm_pkg::remaining_t pend_remaining;

  rcrm_pkg::kind_t out_kind;

  logic [AW-1:0] ram_addr;
  logic          ram_we;
  logic [CW-1:0] ram_wdata;
  logic [CW-1:0] ram_rdata;

  logic [SW-1:0]   w_idx;
  logic [RW-1:0]   r_idx;
  logic [RW-1:0]   k_idx;
  logic [SW-1:0]   s_idx;
  logic [RW-1:0]   s_want;
  logic            w_ok;
  logic            r_ok;
  logic            s_ok;
  logic            want_ok;
  rcrm_pkg::slot_t st;
  logic [CW-1:0]   avail_r;
  logic [CW-1:0]   avail_s;
  logic [CW-1:0]   avail_s_dec;
  logic            run_ok;
  logic            claim_ok;
  logic            claim_grant;
  logic            release_ok;
  logic            activate_ok;
  logic            wakeable;
  logic            push;

  rcrm_pkg::kind_t     dec_kind;
  rcrm_pkg::resource_t dec_resource;
  logic [CW-1:0]       dec_count;

  assign w_idx   = SW'(req_worker);
  assign r_idx   = RW'(req_resource);
  assign k_idx   = cnt[RW-1:0];
  assign s_idx   = cnt[SW-1:0];
  assign w_ok    = int'(req_worker) < WORKER_SLOTS;
  assign r_ok    = int'(req_resource) < RESOURCE_KINDS;
  assign s_ok    = int'(s_idx) < WORKER_SLOTS;
  assign st      = w_ok ? slot_state[w_idx] : rcrm_pkg::SLOT_FREE;
  assign avail_r = r_ok ? available[r_idx] : '0;
  assign s_want  = s_ok ? wanted[s_idx] : '0;
  assign want_ok = int'(s_want) < RESOURCE_KINDS;
  assign avail_s = want_ok ? available[s_want] : '0;
  assign avail_s_dec = avail_s - 1'b1;

  assign run_ok      = w_ok && r_ok && (st == rcrm_pkg::SLOT_RUNNING);
  assign claim_ok    = run_ok && (req_action == rcrm_pkg::ACT_CLAIM);
  assign claim_grant = claim_ok && (avail_r != '0);
  assign release_ok  = run_ok && (req_action == rcrm_pkg::ACT_RELEASE) && (ram_rdata != '0);
  assign activate_ok = w_ok && (req_action == rcrm_pkg::ACT_ACTIVATE)
                       && (st == rcrm_pkg::SLOT_FREE);
  assign wakeable    = s_ok && (slot_state[s_idx] == rcrm_pkg::SLOT_BLOCKED) && (avail_s != '0);

  assign push = (cmd.op == rcrm_pkg::OP_WWR) || (cmd.op == rcrm_pkg::OP_FLUSH);

  assign stat.term_go       = w_ok && (req_action == rcrm_pkg::ACT_TERMINATE)
                              && (st != rcrm_pkg::SLOT_FREE);
  assign stat.wakeable      = wakeable;
  assign stat.out_free      = !out_valid || out_ready;
  assign stat.cnt_last_addr = &cnt;
  assign stat.cnt_last_slot = cnt == AW'(WORKER_SLOTS - 1);
  assign stat.cnt_last_kind = cnt == AW'(RESOURCE_KINDS - 1);

  // first result of the item; errors leave everything unchanged
  always_comb begin
    dec_kind     = rcrm_pkg::KIND_ERROR;
    dec_resource = req_resource;
    dec_count    = '0;
    if (claim_grant) begin
      dec_kind  = rcrm_pkg::KIND_GRANTED;
      dec_count = avail_r - 1'b1;
    end else if (claim_ok) begin
      dec_kind  = rcrm_pkg::KIND_BLOCKED;
      dec_count = avail_r;
    end else if (release_ok) begin
      dec_kind  = rcrm_pkg::KIND_RELEASED;
      dec_count = avail_r + 1'b1;
    end else if (activate_ok) begin
      dec_kind     = rcrm_pkg::KIND_DONE;
      dec_resource = '0;
    end
  end

  always_comb begin
    unique case (cmd.op) inside
      rcrm_pkg::OP_CLEAR:                 ram_addr = cnt;
      rcrm_pkg::OP_TRD, rcrm_pkg::OP_TWR:  ram_addr = {w_idx, k_idx};
      rcrm_pkg::OP_SCAN, rcrm_pkg::OP_WWR: ram_addr = {s_idx, s_want};
      default:                            ram_addr = {w_idx, r_idx};
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = '0;
    unique case (cmd.op) inside
      rcrm_pkg::OP_CLEAR, rcrm_pkg::OP_TWR: ram_we = 1'b1;
      rcrm_pkg::OP_WWR: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata + 1'b1;
      end
      rcrm_pkg::OP_DECIDE: begin
        ram_we    = claim_grant || release_ok;
        ram_wdata = claim_grant ? ram_rdata + 1'b1 : ram_rdata - 1'b1;
      end
      default: ram_we = 1'b0;
    endcase
  end

  rcrm_ram #(
    .WIDTH(CW),
    .DEPTH(DEPTH)
  ) u_held (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < WORKER_SLOTS; i++) begin
        slot_state[i] <= rcrm_pkg::SLOT_FREE;
        wanted[i]     <= '0;
      end
      for (int j = 0; j < RESOURCE_KINDS; j++) begin
        available[j] <= CW'(INSTANCES);
      end
    end else begin
      if (cmd.cnt_clr) begin
        cnt <= '0;
      end else if (cmd.cnt_inc) begin
        cnt <= cnt + 1'b1;
      end

      if (push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (cmd.op)
        rcrm_pkg::OP_DECIDE: begin
          if (claim_ok) wanted[w_idx] <= r_idx;
          if (claim_grant) begin
            available[r_idx] <= avail_r - 1'b1;
          end else if (claim_ok) begin
            slot_state[w_idx] <= rcrm_pkg::SLOT_BLOCKED;
          end
          if (release_ok) available[r_idx] <= avail_r + 1'b1;
          if (activate_ok) slot_state[w_idx] <= rcrm_pkg::SLOT_RUNNING;
        end
        rcrm_pkg::OP_TWR: begin
          available[k_idx] <= available[k_idx] + ram_rdata;
        end
        rcrm_pkg::OP_TDONE: begin
          slot_state[w_idx] <= rcrm_pkg::SLOT_FREE;
          wanted[w_idx]     <= '0;
        end
        rcrm_pkg::OP_WWR: begin
          available[s_want] <= avail_s_dec;
          slot_state[s_idx] <= rcrm_pkg::SLOT_RUNNING;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == rcrm_pkg::OP_ACCEPT) begin
      req_action   <= rcrm_pkg::act_t'(action);
      req_worker   <= worker;
      req_resource <= resource;
    end

    if (push) begin
      out_kind     <= pend_kind;
      worker_out   <= pend_worker;
      resource_out <= pend_resource;
      remaining    <= pend_remaining;
      last         <= cmd.op == rcrm_pkg::OP_FLUSH;
    end

    unique case (cmd.op)
      rcrm_pkg::OP_DECIDE: begin
        pend_kind      <= dec_kind;
        pend_worker    <= req_worker;
        pend_resource  <= dec_resource;
        pend_remaining <= rcrm_pkg::remaining_t'(dec_count);
      end
      rcrm_pkg::OP_TDONE: begin
        pend_kind      <= rcrm_pkg::KIND_DONE;
        pend_worker    <= req_worker;
        pend_resource  <= '0;
        pend_remaining <= '0;
      end
      rcrm_pkg::OP_WWR: begin
        pend_kind      <= rcrm_pkg::KIND_WOKEN;
        pend_worker    <= rcrm_pkg::worker_t'(s_idx);
        pend_resource  <= rcrm_pkg::resource_t'(s_want);
        pend_remaining <= rcrm_pkg::remaining_t'(avail_s_dec);
      end
      default: ;
    endcase
  end

  assign kind = out_kind;

endmodule

// File: rtl/resource_claim_release_manager.sv
// one item at a time: accept, held-count lookup and decision (IDLE, LOOK, DECIDE), then the wake
// scan visits one worker slot a cycle while no slot wakes, and stops on each woken slot
// until the output is free to take its result; a terminate first sweeps its held-count row
// in the single-port memory, returning each entry to the pool and zeroing it
// results leave through an output register; a stalled output holds the scan at its next result
// synchronous reset, then the held-count memory is zeroed one entry a cycle (512 at defaults)
module resource_claim_release_manager #(
  parameter int WORKER_SLOTS   = rcrm_pkg::DEF_WORKER_SLOTS,
  parameter int RESOURCE_KINDS = rcrm_pkg::DEF_RESOURCE_KINDS,
  parameter int INSTANCES      = rcrm_pkg::DEF_INSTANCES
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [rcrm_pkg::ACTION_W-1:0] action,
  input  rcrm_pkg::worker_t             worker,
  input  rcrm_pkg::resource_t           resource,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rcrm_pkg::KIND_W-1:0]   kind,
  output rcrm_pkg::worker_t             worker_out,
  output rcrm_pkg::resource_t           resource_out,
  output rcrm_pkg::remaining_t          remaining,
  output logic                          last
);

  rcrm_pkg::cmd_t  cmd;
  rcrm_pkg::stat_t stat;

  rcrm_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .stat    (stat),
    .cmd     (cmd)
  );

  rcrm_dp #(
    .WORKER_SLOTS  (WORKER_SLOTS),
    .RESOURCE_KINDS(RESOURCE_KINDS),
    .INSTANCES     (INSTANCES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .action      (action),
    .worker      (worker),
    .resource    (resource),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .kind        (kind),
    .worker_out  (worker_out),
    .resource_out(resource_out),
    .remaining   (remaining),
    .last        (last)
  );

  // memory clearing keeps the input closed right after reset
  a_clear_after_reset: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("input open during clearing pass");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in work");

  a_wake_pushes: assert property (@(posedge clk) disable iff (rst)
    cmd.op == rcrm_pkg::OP_WWR |=> out_valid && !last)
    else $error("wakeup did not hand over a non-final result");

  a_flush_last: assert property (@(posedge clk) disable iff (rst)
    cmd.op == rcrm_pkg::OP_FLUSH |=> out_valid && last)
    else $error("final result not marked last");

endmodule
